// ===== hw/rtl/clns_pkg.sv =====
// Shared types, constants and lookup functions for the character LCD nibble sequencer.
// Imported by the decode front end, the command queue, the pin engine and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clns_pkg;

    // Stream word widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    // Default depth of the queue between front end and engine
    localparam int QUEUE_DEPTH_DEF = 4;

    // Item kinds as carried on s_tuser
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_CURSOR = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_INIT   = 3'd4;

    // Timing constants in microsecond ticks
    localparam logic [15:0] CURSOR_HOLD_US = 16'd100;
    localparam logic [15:0] CLEAR_HOLD_US  = 16'd2000;
    localparam logic [10:0] CLEAR_EXTRA_US = 11'd1500;
    localparam logic [15:0] INIT_POWER_US  = 16'd15000;
    localparam logic [15:0] INIT_HOLD_US   = 16'd10;
    localparam int          INIT_LEN       = 14;

    // Fixed command bytes
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] LINE2_OFFSET   = 8'h40;

    // Classified operation handed from front end to engine
    typedef enum logic [1:0] {
        OP_NONE,
        OP_TICK,
        OP_BYTE,
        OP_INIT
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  byte_val;
        logic        sel;
        logic [15:0] hold;
        logic [10:0] extra;
    } op_t;

    // Queue head as seen by the engine
    typedef struct packed {
        logic valid;
        op_t  op;
    } head_t;

    // Nibble of each step of the power-on program; steps past the end read as the last one
    function automatic logic [3:0] init_nib(input logic [3:0] step);
        logic [3:0] nib;
        case (step)
            4'd0, 4'd1, 4'd2:               nib = 4'h3;
            4'd3, 4'd4:                     nib = 4'h2;
            4'd5:                           nib = 4'hC;
            4'd6, 4'd8, 4'd10, 4'd12:       nib = 4'h0;
            4'd7:                           nib = 4'h8;
            4'd9:                           nib = 4'h1;
            4'd11:                          nib = 4'h7;
            default:                        nib = 4'hC;
        endcase
        return nib;
    endfunction

    // Enable-low time after each step of the power-on program
    function automatic logic [12:0] init_low(input logic [3:0] step);
        logic [12:0] low;
        case (step)
            4'd0:                                   low = 13'd5000;
            4'd1:                                   low = 13'd150;
            4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd10,
            4'd12:                                  low = 13'd10;
            4'd5:                                   low = 13'd1;
            default:                                low = 13'd0;
        endcase
        return low;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/clns_front.sv =====
// Front end: unpacks an incoming word and classifies it into a queued operation.
// Builds the instruction byte for cursor moves and clears. Depends on clns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clns_front (
    input  logic [clns_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [clns_pkg::S_TUSER_W-1:0] s_tuser,
    output clns_pkg::op_t                  op
);
    import clns_pkg::*;

    logic [7:0]  byte_value;
    logic        register_select;
    logic [15:0] hold_us;
    logic [5:0]  column;
    logic [1:0]  row;
    logic [7:0]  cursor_byte;

    // Unpack payload fields
    assign byte_value      = s_tdata[7:0];
    assign register_select = s_tdata[8];
    assign hold_us         = s_tdata[24:9];
    assign column          = s_tdata[30:25];
    assign row             = s_tdata[32:31];

    // Address byte: only bit 1 of row picks the second line, column wraps below one
    assign cursor_byte = CMD_SET_DDRAM | (row[1] ? LINE2_OFFSET : 8'h00)
                       | ({2'b00, column} - 8'd1);

    // Classify by kind
    always_comb
    begin
        op          = '0;
        op.kind     = OP_NONE;
        unique case (s_tuser)
            KIND_TICK:
            begin
                op.kind = OP_TICK;
            end
            KIND_WRITE:
            begin
                op.kind     = OP_BYTE;
                op.byte_val = byte_value;
                op.sel      = register_select;
                op.hold     = hold_us;
            end
            KIND_CURSOR:
            begin
                op.kind     = OP_BYTE;
                op.byte_val = cursor_byte;
                op.hold     = CURSOR_HOLD_US;
            end
            KIND_CLEAR:
            begin
                op.kind     = OP_BYTE;
                op.byte_val = CMD_CLEAR;
                op.hold     = CLEAR_HOLD_US;
                op.extra    = CLEAR_EXTRA_US;
            end
            KIND_INIT:
            begin
                op.kind = OP_INIT;
            end
            default:
            begin
                op.kind = OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clns_queue.sv =====
// Short queue of classified operations between front end and engine.
// Circular buffer in flip-flops with a fill count. Depends on clns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clns_queue #(
    parameter int DEPTH = clns_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  clns_pkg::op_t   push_op,
    output logic            full,
    input  logic            pop,
    output clns_pkg::head_t head
);
    import clns_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    op_t           slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.op    = slot_reg[rd_ptr_reg];

    // Advance pointers with explicit wrap, track fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clns_engine.sv =====
// Back end: plays out nibble programs on the LCD pins, one queued operation per cycle while the output is free.
// Holds the phase machine, countdown and output register. Depends on clns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clns_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  clns_pkg::head_t                head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [clns_pkg::M_TDATA_W-1:0] m_tdata
);
    import clns_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HI,
        PH_MID,
        PH_LO,
        PH_TAIL,
        PH_IPOWER,
        PH_IPULSE,
        PH_IGAP
    } phase_t;

    phase_t      phase_reg, phase_next, enter_ph;
    logic [15:0] countdown_reg, countdown_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_sel_reg, held_sel_next;
    logic [15:0] held_hold_reg, held_hold_next;
    logic [10:0] extra_reg, extra_next;
    logic [3:0]  init_step_reg, init_step_next;
    logic        ready_reg, ready_next;
    logic        rs_reg, rs_next;
    logic        en_reg, en_next;
    logic [3:0]  data_reg, data_next;
    logic        out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic        go_enter;
    logic        rej;
    logic        busy;
    logic [12:0] low_time;

    assign busy     = (phase_reg != PH_IDLE);
    assign pop      = head.valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign low_time = init_low(init_step_next);

    // Work out the effect of the head operation and the phase it enters
    always_comb
    begin
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        held_byte_next = held_byte_reg;
        held_sel_next  = held_sel_reg;
        held_hold_next = held_hold_reg;
        extra_next     = extra_reg;
        init_step_next = init_step_reg;
        ready_next     = ready_reg;
        rs_next        = rs_reg;
        en_next        = en_reg;
        data_next      = data_reg;
        go_enter       = 1'b0;
        enter_ph       = PH_IDLE;
        rej            = 1'b0;

        if (pop)
        begin
            unique case (head.op.kind)
                OP_TICK:
                begin
                    if (busy)
                    begin
                        if (countdown_reg > 16'd1)
                        begin
                            countdown_next = countdown_reg - 16'd1;
                        end
                        else
                        begin
                            go_enter = 1'b1;
                            unique case (phase_reg)
                                PH_HI:     enter_ph = PH_MID;
                                PH_MID:    enter_ph = PH_LO;
                                PH_LO:     enter_ph = PH_TAIL;
                                PH_IPOWER:
                                begin
                                    init_step_next = '0;
                                    enter_ph       = PH_IPULSE;
                                end
                                PH_IPULSE: enter_ph = PH_IGAP;
                                PH_IGAP:
                                begin
                                    if (init_step_reg < 4'(INIT_LEN - 1))
                                    begin
                                        init_step_next = init_step_reg + 4'd1;
                                        enter_ph       = PH_IPULSE;
                                    end
                                    else
                                    begin
                                        ready_next = 1'b1;
                                        enter_ph   = PH_IDLE;
                                    end
                                end
                                default:   enter_ph = PH_IDLE;
                            endcase
                        end
                    end
                end
                OP_BYTE:
                begin
                    if (busy)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        held_byte_next = head.op.byte_val;
                        held_sel_next  = head.op.sel;
                        held_hold_next = head.op.hold;
                        extra_next     = head.op.extra;
                        go_enter       = 1'b1;
                        enter_ph       = PH_HI;
                    end
                end
                OP_INIT:
                begin
                    if (busy)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        init_step_next = '0;
                        go_enter       = 1'b1;
                        enter_ph       = PH_IPOWER;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Load the entered phase: its count and its pins
        if (go_enter)
        begin
            phase_next = enter_ph;
            unique case (enter_ph)
                PH_HI:
                begin
                    countdown_next = (held_hold_next == '0) ? 16'd1 : held_hold_next;
                    rs_next        = held_sel_next;
                    en_next        = 1'b1;
                    data_next      = held_byte_next[7:4];
                end
                PH_MID:
                begin
                    countdown_next = 16'd1;
                    rs_next        = held_sel_next;
                    en_next        = 1'b0;
                    data_next      = held_byte_next[7:4];
                end
                PH_LO:
                begin
                    countdown_next = (held_hold_next == '0) ? 16'd1 : held_hold_next;
                    rs_next        = held_sel_next;
                    en_next        = 1'b1;
                    data_next      = held_byte_next[3:0];
                end
                PH_TAIL:
                begin
                    countdown_next = (extra_next == '0) ? 16'd1 : {5'd0, extra_next};
                    rs_next        = held_sel_next;
                    en_next        = 1'b0;
                    data_next      = held_byte_next[3:0];
                end
                PH_IPOWER:
                begin
                    countdown_next = INIT_POWER_US;
                    en_next        = 1'b0;
                end
                PH_IPULSE:
                begin
                    countdown_next = INIT_HOLD_US;
                    rs_next        = 1'b0;
                    en_next        = 1'b1;
                    data_next      = init_nib(init_step_next);
                end
                PH_IGAP:
                begin
                    countdown_next = (low_time == '0) ? 16'd1 : {3'd0, low_time};
                    rs_next        = 1'b0;
                    en_next        = 1'b0;
                    data_next      = init_nib(init_step_next);
                end
                default:
                begin
                    phase_next     = PH_IDLE;
                    countdown_next = '0;
                    en_next        = 1'b0;
                end
            endcase
        end
    end

    // Hold a finished word until taken; refill on every pop
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {7'd0, rej, ready_next, (phase_next != PH_IDLE),
                              data_next, en_next, rs_next};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            countdown_reg <= '0;
            held_byte_reg <= '0;
            held_sel_reg  <= 1'b0;
            held_hold_reg <= '0;
            extra_reg     <= '0;
            init_step_reg <= '0;
            ready_reg     <= 1'b0;
            rs_reg        <= 1'b0;
            en_reg        <= 1'b0;
            data_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            held_byte_reg <= held_byte_next;
            held_sel_reg  <= held_sel_next;
            held_hold_reg <= held_hold_next;
            extra_reg     <= extra_next;
            init_step_reg <= init_step_next;
            ready_reg     <= ready_next;
            rs_reg        <= rs_next;
            en_reg        <= en_next;
            data_reg      <= data_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Enable is only driven high in a pulse phase
    a_enable_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        en_reg |-> (phase_reg == PH_HI || phase_reg == PH_LO || phase_reg == PH_IPULSE))
        else $error("enable high outside a pulse phase");

    // A running phase always has time left
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (countdown_reg != '0))
        else $error("active phase with zero countdown");

    // Ready never drops once set
    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ready_reg))
        else $error("ready flag fell");

    // A dropped command is only reported while a program runs
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[8]) |-> out_data_reg[6])
        else $error("command rejected while idle");

endmodule

`default_nettype wire

// ===== hw/rtl/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer: front end, queue and pin engine.
// Depends on clns_pkg, clns_front, clns_queue and clns_engine.
`timescale 1ns / 1ps
`default_nettype none

// Drives an HD44780-style display over a 4-bit bus. Each input word is a one-microsecond
// tick or a command (write, cursor move, clear, init), chosen by s_tuser; commands load a
// nibble program that later ticks play out, and every word returns one status word with
// the pin levels, busy, ready and a reject flag. Commands that arrive while a program runs
// are dropped and flagged. The block takes one word per clock unless the queue is full;
// the front end classifies it into a queue of QUEUE_DEPTH entries, and the engine
// resolves one queued operation per cycle, unless its output word waits for m_tready,
// into a registered output word, and each side stalls independently of the other.
module char_lcd_nibble_sequencer #(
    parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // byte_value[7:0], register_select[8], hold_us[24:9], column[30:25], row[32:31]
    input  logic [clns_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[2:0]
    input  logic [clns_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // rs_pin[0], enable_pin[1], data_nibble[5:2], busy_res[6], ready_res[7], rejected[8]
    output logic [clns_pkg::M_TDATA_W-1:0] m_tdata
);
    import clns_pkg::*;

    op_t   front_op;
    head_t queue_head;
    logic  queue_full;
    logic  engine_pop;

    assign s_tready = !queue_full;

    // Classify incoming word
    clns_front u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .op      (front_op)
    );

    // Buffer operations between the two sides
    clns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (s_tvalid),
        .push_op (front_op),
        .full    (queue_full),
        .pop     (engine_pop),
        .head    (queue_head)
    );

    // Play out programs and emit status words
    clns_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (queue_head),
        .pop      (engine_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
